### sv/srcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srcl_pkg;

    localparam int CHANNEL_COUNT_DEF = 8;

    // item and result field widths
    localparam int OP_W   = 1;
    localparam int ADC_W  = 12;
    localparam int IDX_W  = 3;
    localparam int ANG_W  = 8;
    localparam int EV_W   = 2;
    localparam int OCH_W  = 3;
    localparam int MA_W   = 20;
    localparam int PH_W   = 2;

    // per-channel state
    localparam int FRAC_W    = 8;
    localparam int ANGLE_Q_W = ANG_W + FRAC_W;
    localparam int RAMP_W    = 16;
    // averages and samples never exceed 4095 * 65535 < 2**28
    localparam int AVG_W     = MA_W + FRAC_W;
    localparam int CUR_W     = AVG_W;

    // configuration registers
    localparam int SCALE_W = 16;
    localparam int LIMIT_W = 20;
    localparam int STEP_W  = 12;
    localparam int SPC_W   = 8;
    localparam int GRACE_W = 16;
    localparam int ATTEN_W = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 20'd1000;
    localparam logic [STEP_W-1:0]  STEP_RST  = 12'd256;
    localparam logic [SPC_W-1:0]   SPC_RST   = 8'd16;
    localparam logic [GRACE_W-1:0] GRACE_RST = 16'd200;
    localparam logic [ATTEN_W-1:0] ATTEN_RST = 8'h60;

    // divide by ten: x * ceil(2**32 / 10) >> 32, exact for x < 2**30
    localparam int               DIV10_SHIFT   = 32;
    localparam int               DIV10_RECIP_W = 29;
    localparam logic [DIV10_RECIP_W-1:0] DIV10_RECIP = 29'd429496730;
    localparam int               CUR10_W       = 25;

    // divide by 1000: x * ceil(2**39 / 1000) >> 39, exact for x < 2**32
    localparam int               DIV1000_SHIFT   = 39;
    localparam int               DIV1000_RECIP_W = 30;
    localparam logic [DIV1000_RECIP_W-1:0] DIV1000_RECIP = 30'd549755814;
    localparam int               NUM_W  = AVG_W + 2;
    localparam int               MAG_W  = AVG_W + 1;
    localparam int               QUO_W  = 20;
    localparam logic [NUM_W-1:0] AVG_ROUND = 30'd500;
    localparam logic [NUM_W-1:0] AVG_CEIL  = 30'd999;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT_SCALE,
        CFG_CURRENT_LIMIT,
        CFG_ANGLE_STEP,
        CFG_SAMPLES_PER_CH,
        CFG_GRACE,
        CFG_ATTEN
    } cfg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE,
        OP_TARGET
    } op_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE,
        EV_DONE,
        EV_OVER
    } event_t;

    typedef enum logic [PH_W-1:0] {
        PH_RAMP,
        PH_STOPPED,
        PH_REACHED
    } phase_t;

    typedef struct packed {
        logic [SCALE_W-1:0] current_scale_q8;
        logic [LIMIT_W-1:0] current_limit_ma;
        logic [STEP_W-1:0]  angle_step_q8;
        logic [SPC_W-1:0]   samples_per_channel;
        logic [GRACE_W-1:0] grace_samples;
        logic [ATTEN_W-1:0] attenuated_channels;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_Q_W-1:0] angle_q8;
        logic [ANG_W-1:0]     target;
        phase_t               phase;
        logic [RAMP_W-1:0]    ramp_count;
        logic [AVG_W-1:0]     avg_q8;
    } entry_t;

    typedef struct packed {
        op_t              op;
        logic             ch_ok;
        logic [ANG_W-1:0] target_in;
        entry_t           ent;
        logic             neg;
        logic [QUO_W-1:0] quo;
    } step_in_t;

    typedef struct packed {
        entry_t ent;
        event_t ev;
    } step_out_t;

    function automatic logic [ANG_W-1:0] start_angle(input logic [OCH_W-1:0] c);
        logic [ANG_W-1:0] a;
        case (c)
            3'd0:    a = 8'd30;
            3'd1:    a = 8'd150;
            3'd2:    a = 8'd30;
            3'd3:    a = 8'd150;
            3'd4:    a = 8'd40;
            3'd5:    a = 8'd30;
            3'd6:    a = 8'd150;
            default: a = 8'd140;
        endcase
        return a;
    endfunction

    function automatic entry_t reset_entry(input logic [OCH_W-1:0] c);
        entry_t e;
        e.angle_q8   = {start_angle(c), {FRAC_W{1'b0}}};
        e.target     = start_angle(c);
        e.phase      = PH_RAMP;
        e.ramp_count = '0;
        e.avg_q8     = '0;
        return e;
    endfunction

endpackage

`default_nettype wire

### sv/srcl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srcl_in_if;
    import srcl_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [ADC_W-1:0] adc_value;
    logic [IDX_W-1:0] servo_index;
    logic [ANG_W-1:0] target_angle;

    modport source (output valid, operation, adc_value, servo_index, target_angle,
                    input ready);
    modport sink   (input valid, operation, adc_value, servo_index, target_angle,
                    output ready);
endinterface

interface srcl_out_if;
    import srcl_pkg::*;

    logic             valid;
    logic             ready;
    logic [EV_W-1:0]  event_res;
    logic [OCH_W-1:0] channel;
    logic [ANG_W-1:0] angle_now;
    logic [MA_W-1:0]  avg_current_ma;
    logic [PH_W-1:0]  phase_now;

    modport source (output valid, event_res, channel, angle_now, avg_current_ma, phase_now,
                    input ready);
    modport sink   (input valid, event_res, channel, angle_now, avg_current_ma, phase_now,
                    output ready);
endinterface

interface srcl_cfg_if;
    import srcl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/servo_ramp_current_limiter.sv
`timescale 1ns / 1ps
`default_nettype none

// Multichannel servo ramp controller with a current-limited stop. Each beat on
// item is a converter sample for the selected channel (operation 0) or a new
// target angle for one servo (operation 1); each yields exactly one beat on
// result, in order, through stages 1 to 3 and the result register. Per-channel
// state (Q8.8 angle, target, phase, ramp count, Q8 average current) lives in one
// state RAM with a registered read; valid bits stand in for reset values, so there
// is no clearing pass and items are taken from the first cycle after reset. Items
// for different channels enter on consecutive clocks unless the result is held.
// Two items in a row on one channel cannot enter back to back: the second waits
// while the first is in stage 1, as the read-modify-write loop through the state
// RAM spans the averaging stage (multiply by the reciprocal of 1000) and the ramp
// update, with forwarding from the write-back into the RAM read and stage 2. The
// configuration port takes a write on every clock; write only while idle.
module servo_ramp_current_limiter #(
    parameter int CHANNEL_COUNT = srcl_pkg::CHANNEL_COUNT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    srcl_in_if.sink   item,
    srcl_out_if.source result,
    srcl_cfg_if.sink  cfg
);
    import srcl_pkg::*;

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int EW   = $bits(entry_t);

    cfg_t regs;

    // ---------------------------------------------------------------
    // Channel selection and accept logic
    // ---------------------------------------------------------------
    logic [CH_W-1:0]  act_reg, act_next;
    logic [SPC_W-1:0] sc_reg, sc_next;
    logic [CH_W:0]    act_inc;
    logic [SPC_W-1:0] sc_inc;

    op_t                 cand_op;
    logic [CH_W+IDX_W-1:0] idx_wide;
    logic [CH_W+2:0]     act_wide;
    logic                idx_ok;
    logic [CH_W-1:0]     cand_ch;
    logic                cand_ok;
    logic [OCH_W-1:0]    cand_och;
    logic                cand_atten;
    logic                hazard;
    logic                adv;
    logic                accept;

    // state RAM write side (final stage)
    logic                ram_we;
    logic [EW-1:0]       ram_rdata;
    step_out_t           sout;
    step_in_t            sin;

    // pipeline stage 1: RAM read in flight, sample product
    logic                s1_valid_reg, s1_valid_next;
    op_t                 s1_op_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic                s1_ok_reg;
    logic [OCH_W-1:0]    s1_och_reg;
    logic [ANG_W-1:0]    s1_tin_reg;
    logic                s1_atten_reg;
    logic [CUR_W-1:0]    s1_prod_reg;
    logic                s1_vld_reg;
    logic                s1_byp_reg;
    entry_t              s1_bdata_reg;

    // pipeline stage 2: state entry and scaled sample
    logic                s2_valid_reg, s2_valid_next;
    op_t                 s2_op_reg;
    logic [CH_W-1:0]     s2_ch_reg;
    logic                s2_ok_reg;
    logic [OCH_W-1:0]    s2_och_reg;
    logic [ANG_W-1:0]    s2_tin_reg;
    logic [CUR_W-1:0]    s2_cur_reg;
    entry_t              s2_ent_reg;

    // pipeline stage 3: average quotient ready, ramp update
    logic                s3_valid_reg, s3_valid_next;
    op_t                 s3_op_reg;
    logic [CH_W-1:0]     s3_ch_reg;
    logic                s3_ok_reg;
    logic [OCH_W-1:0]    s3_och_reg;
    logic [ANG_W-1:0]    s3_tin_reg;
    entry_t              s3_ent_reg;
    logic                s3_neg_reg;
    logic [QUO_W-1:0]    s3_quo_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [EV_W-1:0]     out_ev_reg;
    logic [OCH_W-1:0]    out_ch_reg;
    logic [ANG_W-1:0]    out_ang_reg;
    logic [MA_W-1:0]     out_ma_reg;
    logic [PH_W-1:0]     out_ph_reg;

    logic [CHANNEL_COUNT-1:0] vld_reg, vld_next;

    srcl_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    always_comb
    begin
        cand_op  = op_t'(item.operation);
        idx_wide = {{CH_W{1'b0}}, item.servo_index};
        act_wide = {3'b000, act_reg};
        idx_ok   = idx_wide < (CH_W+IDX_W)'(CHANNEL_COUNT);
        if (cand_op == OP_TARGET)
        begin
            cand_ch  = idx_wide[CH_W-1:0];
            cand_ok  = idx_ok;
            cand_och = item.servo_index;
        end
        else
        begin
            cand_ch  = act_reg;
            cand_ok  = 1'b1;
            cand_och = act_wide[OCH_W-1:0];
        end
        // only the first eight channels have an attenuation bit
        cand_atten = (act_wide < (CH_W+3)'(ATTEN_W))
                     && regs.attenuated_channels[act_wide[2:0]];
    end

    // The final stage may move a bubble on even while the result waits.
    assign adv    = !s3_valid_reg || !out_valid_reg || result.ready;
    // Back-to-back beats on one channel: the second would read before the
    // first writes back, one stage too late to forward.
    assign hazard = s1_valid_reg && s1_ok_reg && cand_ok && (s1_ch_reg == cand_ch);
    assign item.ready = adv && !hazard;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        act_next = act_reg;
        sc_next  = sc_reg;
        sc_inc   = sc_reg + 1'b1;
        act_inc  = {1'b0, act_reg} + 1'b1;
        if (accept && (cand_op == OP_SAMPLE))
        begin
            sc_next = sc_inc;
            if (sc_inc >= regs.samples_per_channel)
            begin
                sc_next  = '0;
                act_next = (act_inc >= (CH_W+1)'(CHANNEL_COUNT)) ? '0 : act_inc[CH_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // State RAM and valid bits
    // ---------------------------------------------------------------
    assign ram_we = adv && s3_valid_reg && s3_ok_reg;

    srcl_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNEL_COUNT),
        .AW    (CH_W)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s3_ch_reg),
        .wdata (sout.ent),
        .re    (accept),
        .raddr (cand_ch),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        vld_next = vld_reg;
        if (ram_we)
        begin
            vld_next[s3_ch_reg] = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: merge RAM data, divide-by-ten multiply
    // ---------------------------------------------------------------
    entry_t                          s1_ent;
    logic [CUR_W+DIV10_RECIP_W-1:0]  s1_prod10;
    logic [CUR_W-1:0]                s1_cur;

    always_comb
    begin
        if (s1_byp_reg)
        begin
            s1_ent = s1_bdata_reg;
        end
        else if (s1_vld_reg)
        begin
            s1_ent = entry_t'(ram_rdata);
        end
        else
        begin
            s1_ent = reset_entry(s1_och_reg);
        end
        s1_prod10 = (CUR_W+DIV10_RECIP_W)'(s1_prod_reg)
                    * (CUR_W+DIV10_RECIP_W)'(DIV10_RECIP);
        s1_cur    = s1_atten_reg
                    ? CUR_W'(s1_prod10[DIV10_SHIFT+CUR10_W-1:DIV10_SHIFT])
                    : s1_prod_reg;
    end

    // ---------------------------------------------------------------
    // Stage 2: floor((sample + 500 - old) / 1000) by reciprocal
    // ---------------------------------------------------------------
    logic [NUM_W-1:0]                 s2_num;
    logic                             s2_neg;
    logic [NUM_W-1:0]                 s2_mag_full;
    logic [MAG_W+DIV1000_RECIP_W-1:0] s2_qprod;

    always_comb
    begin
        s2_num      = {2'b00, s2_cur_reg} + AVG_ROUND - {2'b00, s2_ent_reg.avg_q8};
        s2_neg      = s2_num[NUM_W-1];
        // negative: floor(d / 1000) = -floor((-d + 999) / 1000)
        s2_mag_full = s2_neg ? (AVG_CEIL - s2_num) : s2_num;
        s2_qprod    = (MAG_W+DIV1000_RECIP_W)'(s2_mag_full[MAG_W-1:0])
                      * (MAG_W+DIV1000_RECIP_W)'(DIV1000_RECIP);
    end

    // ---------------------------------------------------------------
    // Stage 3: average, phase and ramp update
    // ---------------------------------------------------------------
    always_comb
    begin
        sin.op        = s3_op_reg;
        sin.ch_ok     = s3_ok_reg;
        sin.target_in = s3_tin_reg;
        sin.ent       = s3_ent_reg;
        sin.neg       = s3_neg_reg;
        sin.quo       = s3_quo_reg;
    end

    srcl_step u_step (
        .regs (regs),
        .sin  (sin),
        .sout (sout)
    );

    always_comb
    begin
        s1_valid_next = adv ? accept       : s1_valid_reg;
        s2_valid_next = adv ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = adv ? s2_valid_reg : s3_valid_reg;
        if (adv && s3_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= '0;
            sc_reg        <= '0;
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            sc_reg        <= sc_next;
            vld_reg       <= vld_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= cand_op;
            s1_ch_reg    <= cand_ch;
            s1_ok_reg    <= cand_ok;
            s1_och_reg   <= cand_och;
            s1_tin_reg   <= item.target_angle;
            s1_atten_reg <= cand_atten;
            s1_prod_reg  <= CUR_W'(item.adc_value) * CUR_W'(regs.current_scale_q8);
            s1_vld_reg   <= cand_ok && vld_reg[cand_ch];
            // write-back landing on the same edge as the read
            s1_byp_reg   <= ram_we && cand_ok && (s3_ch_reg == cand_ch);
            s1_bdata_reg <= sout.ent;
        end
        if (adv)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_ch_reg  <= s1_ch_reg;
            s2_ok_reg  <= s1_ok_reg;
            s2_och_reg <= s1_och_reg;
            s2_tin_reg <= s1_tin_reg;
            s2_cur_reg <= s1_cur;
            // forward the entry being written back two beats ahead
            if (ram_we && s1_ok_reg && (s3_ch_reg == s1_ch_reg))
            begin
                s2_ent_reg <= sout.ent;
            end
            else
            begin
                s2_ent_reg <= s1_ent;
            end

            s3_op_reg  <= s2_op_reg;
            s3_ch_reg  <= s2_ch_reg;
            s3_ok_reg  <= s2_ok_reg;
            s3_och_reg <= s2_och_reg;
            s3_tin_reg <= s2_tin_reg;
            s3_ent_reg <= s2_ent_reg;
            s3_neg_reg <= s2_neg;
            s3_quo_reg <= s2_qprod[DIV1000_SHIFT+QUO_W-1:DIV1000_SHIFT];
        end
        if (adv && s3_valid_reg)
        begin
            out_ev_reg <= sout.ev;
            out_ch_reg <= s3_och_reg;
            if (s3_ok_reg)
            begin
                out_ang_reg <= sout.ent.angle_q8[ANGLE_Q_W-1:FRAC_W];
                out_ma_reg  <= sout.ent.avg_q8[AVG_W-1:FRAC_W];
                out_ph_reg  <= sout.ent.phase;
            end
            else
            begin
                out_ang_reg <= '0;
                out_ma_reg  <= '0;
                out_ph_reg  <= '0;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.event_res      = out_ev_reg;
    assign result.channel        = out_ch_reg;
    assign result.angle_now      = out_ang_reg;
    assign result.avg_current_ma = out_ma_reg;
    assign result.phase_now      = out_ph_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_adjacent_same_ch: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_valid_reg && s2_ok_reg && s3_ok_reg) |-> (s2_ch_reg != s3_ch_reg))
        else $error("same channel in adjacent update stages");

    a_over_event_settles: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.event_res == EV_OVER)) |-> (result.phase_now == PH_REACHED))
        else $error("overcurrent finish without settled phase");

    a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg < CH_W'(CHANNEL_COUNT - 1) || act_reg == CH_W'(CHANNEL_COUNT - 1))
        else $error("active channel out of range");

    a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> vld_reg[$past(s3_ch_reg)])
        else $error("state entry written but not marked valid");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (s1_valid_reg && (s1_op_reg == $past(cand_op))))
        else $error("accepted beat did not enter the pipeline");

endmodule

`default_nettype wire

### sv/srcl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/srcl_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module srcl_cfg (
    input  wire logic      clk,
    input  wire logic      rst_n,
    srcl_cfg_if.sink       cfg,
    output srcl_pkg::cfg_t regs
);
    import srcl_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_CURRENT_SCALE:  regs_next.current_scale_q8    = cfg.data[SCALE_W-1:0];
                CFG_CURRENT_LIMIT:  regs_next.current_limit_ma    = cfg.data[LIMIT_W-1:0];
                CFG_ANGLE_STEP:     regs_next.angle_step_q8       = cfg.data[STEP_W-1:0];
                CFG_SAMPLES_PER_CH: regs_next.samples_per_channel = cfg.data[SPC_W-1:0];
                CFG_GRACE:          regs_next.grace_samples       = cfg.data[GRACE_W-1:0];
                CFG_ATTEN:          regs_next.attenuated_channels = cfg.data[ATTEN_W-1:0];
                default:            regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.current_scale_q8    <= SCALE_RST;
            regs_reg.current_limit_ma    <= LIMIT_RST;
            regs_reg.angle_step_q8       <= STEP_RST;
            regs_reg.samples_per_channel <= SPC_RST;
            regs_reg.grace_samples       <= GRACE_RST;
            regs_reg.attenuated_channels <= ATTEN_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

### sv/srcl_step.sv
`timescale 1ns / 1ps
`default_nettype none

module srcl_step (
    input  srcl_pkg::cfg_t      regs,
    input  srcl_pkg::step_in_t  sin,
    output srcl_pkg::step_out_t sout
);
    import srcl_pkg::*;

    logic [AVG_W:0]       avg_sum;
    logic [AVG_W-1:0]     avg_new;
    logic                 over;
    logic [RAMP_W-1:0]    ramp_inc;
    logic [ANGLE_Q_W:0]   angle_up;
    logic [ANGLE_Q_W-1:0] step_q;
    logic                 moving;

    always_comb
    begin
        // quotient carries the sign of (sample + 500 - old), floored
        avg_sum = sin.neg ? ({1'b0, sin.ent.avg_q8} - (AVG_W+1)'(sin.quo))
                          : ({1'b0, sin.ent.avg_q8} + (AVG_W+1)'(sin.quo));
        avg_new = avg_sum[AVG_W-1:0];
        over    = avg_new >= {regs.current_limit_ma, {FRAC_W{1'b0}}};

        ramp_inc = (sin.ent.ramp_count != '1) ? sin.ent.ramp_count + 1'b1
                                              : sin.ent.ramp_count;
        step_q   = ANGLE_Q_W'(regs.angle_step_q8);
        angle_up = {1'b0, sin.ent.angle_q8} + {1'b0, step_q};
        moving   = (!over || (ramp_inc < regs.grace_samples))
                   && (sin.ent.target != sin.ent.angle_q8[ANGLE_Q_W-1:FRAC_W]);

        sout.ent = sin.ent;
        sout.ev  = EV_NONE;

        if (sin.op == OP_TARGET)
        begin
            sout.ent.target = sin.target_in;
            sout.ent.phase  = PH_RAMP;
        end
        else
        begin
            sout.ent.avg_q8 = avg_new;
            case (sin.ent.phase)
                PH_RAMP:
                begin
                    sout.ent.ramp_count = ramp_inc;
                    if (moving)
                    begin
                        if ({sin.ent.target, {FRAC_W{1'b0}}} > sin.ent.angle_q8)
                        begin
                            sout.ent.angle_q8 = angle_up[ANGLE_Q_W] ? '1
                                                : angle_up[ANGLE_Q_W-1:0];
                        end
                        else
                        begin
                            sout.ent.angle_q8 = (sin.ent.angle_q8 > step_q)
                                                ? sin.ent.angle_q8 - step_q : '0;
                        end
                    end
                    else if (over)
                    begin
                        sout.ent.phase = PH_STOPPED;
                    end
                    else
                    begin
                        sout.ent.phase = PH_REACHED;
                        sout.ev        = EV_DONE;
                    end
                end
                PH_STOPPED:
                begin
                    sout.ent.phase = PH_REACHED;
                    sout.ev        = EV_OVER;
                end
                default:
                begin
                    // settled channel: average and ramp count parked at zero
                    sout.ent.ramp_count = '0;
                    sout.ent.avg_q8     = '0;
                end
            endcase
        end

        if (!sin.ch_ok)
        begin
            sout.ev = EV_NONE;
        end
    end

endmodule

`default_nettype wire
